FILE: hdl/lzwc_pkg.sv
// Types and constants shared by the LZW .Z compressor.
`timescale 1ns / 1ps
package lzwc_pkg;
	localparam int MAX_WIDTH_LIMIT = 16;
	localparam int MIN_WIDTH = 9;
	localparam int SLOT_BITS = 17;
	localparam logic [SLOT_BITS-1:0] SLOT_LAST = '1;
	localparam logic [7:0] HDR_MAGIC0 = 8'h1f;
	localparam logic [7:0] HDR_MAGIC1 = 8'h9d;
	localparam logic [7:0] HDR_BLOCK_FLAG = 8'h80;
	localparam logic [16:0] FIRST_FREE = 17'd257;
	localparam logic [4:0] CFG_RESET = 5'd14;
	localparam logic [31:0] HASH_MULT = 32'h9e3779b1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} raw_t;

	typedef struct packed {
		logic [7:0] packed_byte;
		logic       run_last;
		logic       stream_done;
	} zout_t;

	typedef struct packed {
		logic        valid;
		logic [15:0] prefix;
		logic [7:0]  sym;
		logic [15:0] code;
	} slot_t;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_HDR, ST_HASH, ST_ADDR, ST_PROBE, ST_MISS,
		ST_PAD, ST_CODE, ST_FIN, ST_SPILL, ST_FLUSH, ST_DRAIN
	} st_t;
endpackage

FILE: hdl/lzwc_hash.sv
// Slot hash of prefix code and byte, registered after the multiply.
`timescale 1ns / 1ps
module lzwc_hash (
	input  logic                         clk,
	input  logic [15:0]                  prefix,
	input  logic [7:0]                   sym,
	output logic [lzwc_pkg::SLOT_BITS-1:0] slot
);
	import lzwc_pkg::*;

	logic [31:0] key;
	logic [31:0] prod_s1;
	logic [31:0] mix;

	assign key = {8'd0, prefix, sym} ^ ({8'd0, prefix, sym} >> 11);

	always_ff @(posedge clk) begin
		prod_s1 <= key * HASH_MULT;
	end

	assign mix = prod_s1 ^ (prod_s1 >> 15);
	assign slot = mix[SLOT_BITS-1:0];
endmodule

FILE: hdl/lzw_compress_unix_z.sv
// Top level: LZW compressor producing a .Z byte stream.
//
//  channel | signals               | direction | payload
//  raw     | raw_valid, raw_stall  | in        | raw_t  (data_byte, final_byte)
//  z       | z_valid, z_stall      | out       | zout_t (packed_byte, run_last, stream_done)
//  cfg     | cfg_we, cfg_wdata     | in        | max_code_width
//
// A raw byte is taken only in idle; raw_stall stays high while the sequencer hashes, probes
// the dictionary, packs codes and spills output bytes, so a new byte waits until the last is
// done. The first byte of a stream first sends the three header bytes; a width step pads codes.
// The final byte also emits the last code and a flush, then a clearing pass over all slots
// empties the dictionary (also after reset); raw_stall is high meanwhile.
// A stall on z holds the sequencer at its next byte.
`timescale 1ns / 1ps
module lzw_compress_unix_z (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             raw_valid,
	output logic             raw_stall,
	input  lzwc_pkg::raw_t   raw,
	output logic             z_valid,
	input  logic             z_stall,
	output lzwc_pkg::zout_t  z,
	input  logic             cfg_we,
	input  logic [4:0]       cfg_wdata
);
	import lzwc_pkg::*;

	st_t state_q, state_d, ret_q, ret_d;
	logic [1:0]  hdr_cnt_q, hdr_cnt_d;
	logic [7:0]  byte_q, byte_d;
	logic        fin_q, fin_d;
	logic [15:0] cur_q, cur_d;
	logic [16:0] nfc_q, nfc_d;
	logic [4:0]  cw_q, cw_d;
	logic [2:0]  mod8_q, mod8_d;
	logic [23:0] buf_q, buf_d;
	logic [4:0]  fill_q, fill_d;
	logic        started_q, started_d;
	logic [SLOT_BITS-1:0] probe_q, probe_d, clr_q, clr_d;
	logic [7:0]  hold_q, hold_d;
	logic        hold_v_q, hold_v_d;
	zout_t       out_q, out_d;
	logic        out_v_q, out_v_d;
	logic [4:0]  maxw_q;

	slot_t mem [0:(1<<SLOT_BITS)-1];
	slot_t rdata_q;
	logic  mem_we;
	logic [SLOT_BITS-1:0] waddr, rd_addr, hash_slot;
	slot_t wdata;

	logic [4:0]  maxw;
	logic [16:0] code_cap, grow_at;
	logic [15:0] code_mask;
	logic        out_free, push_ok, push, hit, empty, accept;
	logic [7:0]  push_byte;

	lzwc_hash u_hash (.clk(clk), .prefix(cur_q), .sym(byte_q), .slot(hash_slot));

	always_comb begin
		maxw = maxw_q;
		if (maxw_q < 5'(MIN_WIDTH)) maxw = 5'(MIN_WIDTH);
		if (maxw_q > 5'(MAX_WIDTH_LIMIT)) maxw = 5'(MAX_WIDTH_LIMIT);
	end
	assign code_cap  = (17'd1 << maxw) - 17'd1;
	assign grow_at   = (17'd1 << cw_q) + 17'd1;
	assign code_mask = 16'((17'd1 << cw_q) - 17'd1);
	assign out_free  = !out_v_q || !z_stall;
	assign push_ok   = !hold_v_q || out_free;
	assign hit   = rdata_q.valid && rdata_q.prefix == cur_q && rdata_q.sym == byte_q;
	assign empty = !rdata_q.valid;
	assign raw_stall = state_q != ST_IDLE;
	assign accept = raw_valid && !raw_stall;
	assign z_valid = out_v_q;
	assign z = out_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == SLOT_LAST) state_d = ST_IDLE;
			ST_IDLE:  if (raw_valid) state_d = started_q ? ST_HASH : ST_HDR;
			ST_HDR:   if (push_ok && hdr_cnt_q == 2'd2) state_d = fin_q ? ST_FIN : ST_DRAIN;
			ST_HASH:  state_d = ST_ADDR;
			ST_ADDR:  state_d = ST_PROBE;
			ST_PROBE: begin
				if (empty) state_d = ST_MISS;
				else if (hit) state_d = fin_q ? ST_FIN : ST_DRAIN;
			end
			ST_MISS:  state_d = (nfc_q == grow_at) ? ST_PAD : ST_CODE;
			ST_PAD:   state_d = (mod8_q != 3'd0) ? ST_SPILL : ST_CODE;
			ST_CODE:  state_d = ST_SPILL;
			ST_FIN:   state_d = ST_SPILL;
			ST_SPILL: if (fill_q < 5'd8) state_d = ret_q;
			ST_FLUSH: if (fill_q == 5'd0 || push_ok) state_d = ST_DRAIN;
			ST_DRAIN: if (!hold_v_q || out_free) state_d = fin_q ? ST_CLEAR : ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		ret_d = ret_q; hdr_cnt_d = hdr_cnt_q; byte_d = byte_q; fin_d = fin_q;
		cur_d = cur_q; nfc_d = nfc_q; cw_d = cw_q; mod8_d = mod8_q;
		buf_d = buf_q; fill_d = fill_q; started_d = started_q;
		probe_d = probe_q; clr_d = clr_q;
		hold_d = hold_q; hold_v_d = hold_v_q;
		out_d = out_q; out_v_d = out_v_q && z_stall;
		mem_we = 1'b0; waddr = probe_q; wdata = '0; rd_addr = probe_q;
		push = 1'b0; push_byte = buf_q[7:0];
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1; waddr = clr_q; clr_d = clr_q + 1'b1;
			end
			ST_IDLE: if (accept) begin
				byte_d = raw.data_byte; fin_d = raw.final_byte; hdr_cnt_d = 2'd0;
			end
			ST_HDR: if (push_ok) begin
				push = 1'b1;
				unique case (hdr_cnt_q)
					2'd0:    push_byte = HDR_MAGIC0;
					2'd1:    push_byte = HDR_MAGIC1;
					default: push_byte = {3'd0, maxw} | HDR_BLOCK_FLAG;
				endcase
				hdr_cnt_d = hdr_cnt_q + 2'd1;
				if (hdr_cnt_q == 2'd2) begin
					cur_d = {8'd0, byte_q}; started_d = 1'b1;
				end
			end
			ST_HASH: ;
			ST_ADDR: begin
				rd_addr = hash_slot; probe_d = hash_slot;
			end
			ST_PROBE: begin
				if (hit) cur_d = rdata_q.code;
				else if (!empty) begin
					probe_d = probe_q + 1'b1; rd_addr = probe_q + 1'b1;
				end
			end
			ST_MISS: ;
			ST_PAD: begin
				if (mod8_q != 3'd0) begin
					fill_d = fill_q + cw_q; mod8_d = mod8_q + 3'd1; ret_d = ST_PAD;
				end else cw_d = cw_q + 5'd1;
			end
			ST_CODE: begin
				buf_d = buf_q | (24'(cur_q & code_mask) << fill_q);
				fill_d = fill_q + cw_q; mod8_d = mod8_q + 3'd1;
				ret_d = fin_q ? ST_FIN : ST_DRAIN;
				if (nfc_q <= code_cap) begin
					mem_we = 1'b1;
					wdata = '{valid: 1'b1, prefix: cur_q, sym: byte_q, code: nfc_q[15:0]};
					nfc_d = nfc_q + 17'd1;
				end
				cur_d = {8'd0, byte_q};
			end
			ST_FIN: begin
				buf_d = buf_q | (24'(cur_q & code_mask) << fill_q);
				fill_d = fill_q + cw_q; ret_d = ST_FLUSH;
			end
			ST_SPILL: if (fill_q >= 5'd8 && push_ok) begin
				push = 1'b1; buf_d = buf_q >> 8; fill_d = fill_q - 5'd8;
			end
			ST_FLUSH: if (fill_q != 5'd0 && push_ok) begin
				push = 1'b1; buf_d = '0; fill_d = '0;
			end
			ST_DRAIN: if (!hold_v_q || out_free) begin
				if (hold_v_q) begin
					out_d = '{packed_byte: hold_q, run_last: 1'b1, stream_done: fin_q};
					out_v_d = 1'b1; hold_v_d = 1'b0;
				end
				if (fin_q) begin
					cur_d = '0; nfc_d = FIRST_FREE; cw_d = 5'(MIN_WIDTH); mod8_d = '0;
					buf_d = '0; fill_d = '0; started_d = 1'b0; clr_d = '0;
				end
			end
			default: ;
		endcase
		if (push) begin
			if (hold_v_q) begin
				out_d = '{packed_byte: hold_q, run_last: 1'b0, stream_done: 1'b0};
				out_v_d = 1'b1;
			end
			hold_d = push_byte; hold_v_d = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= wdata;
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR; ret_q <= ST_IDLE; hdr_cnt_q <= '0; fin_q <= 1'b0;
			cur_q <= '0; nfc_q <= FIRST_FREE; cw_q <= 5'(MIN_WIDTH); mod8_q <= '0;
			buf_q <= '0; fill_q <= '0; started_q <= 1'b0; clr_q <= '0;
			hold_v_q <= 1'b0; out_v_q <= 1'b0; maxw_q <= CFG_RESET;
		end else begin
			state_q <= state_d; ret_q <= ret_d; hdr_cnt_q <= hdr_cnt_d; fin_q <= fin_d;
			cur_q <= cur_d; nfc_q <= nfc_d; cw_q <= cw_d; mod8_q <= mod8_d;
			buf_q <= buf_d; fill_q <= fill_d; started_q <= started_d; clr_q <= clr_d;
			hold_v_q <= hold_v_d; out_v_q <= out_v_d;
			if (cfg_we) maxw_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		byte_q <= byte_d; probe_q <= probe_d; hold_q <= hold_d; out_q <= out_d;
	end
endmodule

FILE: hdl/lzwc_checker.sv
// Port-level checks for the compressor, bound to the top level.
`timescale 1ns / 1ps
module lzwc_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            raw_valid,
	input logic            raw_stall,
	input lzwc_pkg::raw_t  raw,
	input logic            z_valid,
	input logic            z_stall,
	input lzwc_pkg::zout_t z
);
	import lzwc_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		z_valid && z_stall |=> z_valid) else $error("z transfer dropped under stall");
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		z_valid && z_stall |=> $stable(z)) else $error("z payload moved under stall");
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		z_valid |-> (!z.stream_done || z.run_last)) else $error("stream end not run end");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		raw_valid && !raw_stall |=> raw_stall) else $error("second transfer while busy");
	a_raw_hold: assert property (@(posedge clk) disable iff (!arst_n)
		raw_valid && raw_stall |=> raw_valid && $stable(raw))
		else $error("raw transfer moved under stall");
endmodule

bind lzw_compress_unix_z lzwc_checker u_lzwc_checker (.*);
